// File: src/c8d_pkg.sv
// ----------------------------------------------------------------------------
// c8d_pkg
// Shared constants, types and the CRC-8 bit step for the frame receiver.
// ----------------------------------------------------------------------------
package c8d_pkg;

    localparam int MAX_DATA_BYTES = 15;
    localparam int STORE_AW       = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 2;
    localparam int MLEN_W     = 2;
    localparam int DLEN_W     = 4;
    localparam int MARKER_W   = 24;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 48;

    localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;

    typedef struct packed {
        logic              start;
        logic              init;
        logic [BYTE_W-1:0] data;
    } t_crc_req;

    function automatic logic [BYTE_W-1:0] crc_bit_step(
        input logic [BYTE_W-1:0] crc,
        input logic              din
    );
        logic [BYTE_W-1:0] shifted;
        shifted = crc >> 1;
        return (crc[0] ^ din) ? (shifted ^ CRC_POLY_REFL) : shifted;
    endfunction

endpackage

// File: src/c8d_crc_serial.sv
// ----------------------------------------------------------------------------
// c8d_crc_serial
// Bit-serial reflected CRC-8 engine: folds one byte in, one bit at a time, LSB first.
// ----------------------------------------------------------------------------
module c8d_crc_serial (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  c8d_pkg::t_crc_req         i_req,
    output logic                      o_busy,
    output logic [c8d_pkg::BYTE_W-1:0] o_crc
);
    import c8d_pkg::*;

    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;

    always_comb begin
        n_crc   = r_crc;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_req.start) begin
            n_shift = i_req.data;
            n_cnt   = 3'd0;
            n_busy  = 1'b1;
            if (i_req.init) begin
                n_crc = '0;
            end
        end else if (r_busy) begin
            n_crc   = crc_bit_step(r_crc, r_shift[0]);
            n_shift = r_shift >> 1;
            n_cnt   = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
        r_shift <= n_shift;
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

endmodule

// File: src/crc8_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc8_packet_deframer
// Byte-serial frame receiver with reflected CRC-8 (poly 0x8C, init 0).
// ----------------------------------------------------------------------------
// Each frame is a descriptor byte (type 7:6, marker length 5:4, data length
// 3:0), up to three big-endian marker bytes, the data bytes and a CRC byte.
// Descriptor, marker and data bytes are each followed by the eight steps of
// the bit-serial CRC engine, during which s_tready is low. The CRC byte is
// compared with the engine result; on a match the frame then yields one result
// per data byte (one empty result, tuser low, for a frame without data) at up
// to one per cycle as the output side takes them, and the input side stays
// closed until the last result is loaded into the output register. On a
// mismatch the frame is dropped without output.
// ----------------------------------------------------------------------------
module crc8_packet_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // rx_byte[7:0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // packet_type[1:0], marker[25:2], data_size[29:26], byte_index[33:30],
    // data_byte[41:34], zero pad[47:42]
    output logic [c8d_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tuser,  // has_data[0]
    output logic                            o_m_tlast
);
    import c8d_pkg::*;

    localparam logic [INDEX_W-1:0] MAX_IDX = INDEX_W'(MAX_DATA_BYTES);

    logic                 r_in_frame, n_in_frame;
    logic [COUNT_W-1:0]   r_byte_count, n_byte_count;
    logic [COUNT_W-1:0]   r_frame_len, n_frame_len;
    logic [MLEN_W-1:0]    r_mlen, n_mlen;
    logic [DLEN_W-1:0]    r_dlen, n_dlen;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [MARKER_W-1:0]  r_marker, n_marker;
    logic                 r_emitting, n_emitting;
    logic [INDEX_W-1:0]   r_emit_idx, n_emit_idx;

    logic [BYTE_W-1:0]    r_store [MAX_DATA_BYTES];

    logic                 r_m_valid;
    logic [TYPE_W-1:0]    r_m_type;
    logic [MARKER_W-1:0]  r_m_marker;
    logic [DLEN_W-1:0]    r_m_size;
    logic [INDEX_W-1:0]   r_m_index;
    logic [BYTE_W-1:0]    r_m_byte;
    logic                 r_m_has_data;
    logic                 r_m_last;

    t_crc_req             w_crc_req;
    logic                 w_crc_busy;
    logic [BYTE_W-1:0]    w_crc;

    logic                 w_accept;
    logic [BYTE_W-1:0]    w_b;
    logic [COUNT_W-1:0]   w_pos;
    logic [COUNT_W-1:0]   w_idx;
    logic                 w_store_we;
    logic                 w_load;
    logic [INDEX_W-1:0]   w_shown;
    logic                 w_emit_last;

    c8d_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_crc_req),
        .o_busy  (w_crc_busy),
        .o_crc   (w_crc)
    );

    assign o_s_tready = !w_crc_busy && !r_emitting;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_b        = i_s_tdata;
    assign w_pos      = r_byte_count - COUNT_W'(1);
    assign w_idx      = w_pos - COUNT_W'(r_mlen);

    assign w_load      = r_emitting && (!r_m_valid || i_m_tready);
    assign w_shown     = (r_dlen > MAX_IDX) ? MAX_IDX : r_dlen;
    assign w_emit_last = (r_dlen == '0) || (r_emit_idx == w_shown - INDEX_W'(1));

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_frame_len  = r_frame_len;
        n_mlen       = r_mlen;
        n_dlen       = r_dlen;
        n_type       = r_type;
        n_marker     = r_marker;
        n_emitting   = r_emitting;
        n_emit_idx   = r_emit_idx;
        w_store_we   = 1'b0;
        w_crc_req    = '{start: 1'b0, init: 1'b0, data: w_b};

        if (w_accept) begin
            if (!r_in_frame) begin
                n_type       = w_b[7:6];
                n_mlen       = w_b[5:4];
                n_dlen       = w_b[3:0];
                n_frame_len  = COUNT_W'(w_b[5:4]) + COUNT_W'(w_b[3:0]) + COUNT_W'(2);
                n_byte_count = COUNT_W'(1);
                n_marker     = '0;
                n_in_frame   = 1'b1;
                w_crc_req.start = 1'b1;
                w_crc_req.init  = 1'b1;
            end else if (r_byte_count < r_frame_len - COUNT_W'(1)) begin
                if (w_pos < COUNT_W'(r_mlen)) begin
                    n_marker = {r_marker[MARKER_W-BYTE_W-1:0], w_b};
                end else if (w_idx < COUNT_W'(MAX_DATA_BYTES)) begin
                    w_store_we = 1'b1;
                end
                n_byte_count    = r_byte_count + COUNT_W'(1);
                w_crc_req.start = 1'b1;
            end else begin
                n_in_frame   = 1'b0;
                n_byte_count = '0;
                n_frame_len  = '0;
                if (w_crc == w_b) begin
                    n_emitting = 1'b1;
                    n_emit_idx = '0;
                end
            end
        end

        if (w_load) begin
            if (w_emit_last) begin
                n_emitting = 1'b0;
            end else begin
                n_emit_idx = r_emit_idx + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_frame_len  <= '0;
            r_mlen       <= '0;
            r_dlen       <= '0;
            r_type       <= '0;
            r_marker     <= '0;
            r_emitting   <= 1'b0;
            r_emit_idx   <= '0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_byte_count <= n_byte_count;
            r_frame_len  <= n_frame_len;
            r_mlen       <= n_mlen;
            r_dlen       <= n_dlen;
            r_type       <= n_type;
            r_marker     <= n_marker;
            r_emitting   <= n_emitting;
            r_emit_idx   <= n_emit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[w_idx[STORE_AW-1:0]] <= w_b;
        end
    end

    // load one result per free slot; read the store here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_load) begin
            r_m_type     <= r_type;
            r_m_marker   <= r_marker;
            r_m_size     <= r_dlen;
            r_m_index    <= r_emit_idx;
            r_m_has_data <= (r_dlen != '0);
            r_m_last     <= w_emit_last;
            r_m_byte     <= (r_dlen != '0) ? r_store[r_emit_idx[STORE_AW-1:0]] : '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_byte, r_m_index, r_m_size, r_m_marker, r_m_type};
    assign o_m_tuser  = r_m_has_data;
    assign o_m_tlast  = r_m_last;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_byte_count != '0) && (r_byte_count < r_frame_len))
        else $error("byte count outside frame");

    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> !r_in_frame)
        else $error("emitting while a frame is open");

    a_crc_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_crc_busy) |-> ##8 !w_crc_busy)
        else $error("crc engine did not finish in eight steps");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_has_data) |-> (r_m_last && r_m_index == '0 && r_m_byte == '0))
        else $error("malformed empty result");
`endif

endmodule
